// File: rtl/ebc_pkg.sv
// Shared constants, pipeline item type and modular step functions for the byte cipher.
package ebc_pkg;

  localparam int MOD_W    = 19;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int STEPS_A  = MOD_W * MOD_W;
  localparam int STEPS_B  = MOD_W * MOD_W;
  localparam int STEPS_C  = MOD_W;
  localparam int NUM_STG  = STEPS_A + STEPS_B + STEPS_C;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic REG_PRIME   = 1'b0;
  localparam logic REG_PRIVATE = 1'b1;

  localparam logic [MOD_W-1:0] PRIME_RESET   = MOD_W'(257);
  localparam logic [MOD_W-1:0] PRIVATE_RESET = MOD_W'(1);
  localparam logic [MOD_W-1:0] BYTE_MAX      = MOD_W'(255);

  // One item in flight: two exponentiation lanes plus the partial products of a round
  typedef struct packed {
    logic             cmd;
    logic             bad;
    logic [MOD_W-1:0] p;
    logic [MOD_W-1:0] e0;
    logic [MOD_W-1:0] e1;
    logic [MOD_W-1:0] acc0;
    logic [MOD_W-1:0] sq0;
    logic [MOD_W-1:0] acc1;
    logic [MOD_W-1:0] sq1;
    logic [MOD_W-1:0] pa0;
    logic [MOD_W-1:0] ps0;
    logic [MOD_W-1:0] pa1;
    logic [MOD_W-1:0] ps1;
    logic [MOD_W-1:0] first;
    logic [MOD_W-1:0] mult;
  } item_t;

  // One bit of an interleaved modular multiply, multiplier taken MSB first
  function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] r,
                                                input logic [MOD_W-1:0] a,
                                                input logic             b,
                                                input logic [MOD_W-1:0] p);
    logic [MOD_W+1:0] v;
    logic [MOD_W+1:0] p1;
    logic [MOD_W+1:0] p2;
    v  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
    p1 = {2'b00, p};
    p2 = {1'b0, p, 1'b0};
    if (v >= p2) begin
      v = v - p2;
    end else if (v >= p1) begin
      v = v - p1;
    end
    return v[MOD_W-1:0];
  endfunction

  // Generator 3 reduced by a modulus of 2 or 3; any other modulus keeps 3 as it is
  function automatic logic [MOD_W-1:0] gen_base(input logic [MOD_W-1:0] p);
    logic [MOD_W-1:0] g;
    if (p == MOD_W'(2)) begin
      g = MOD_W'(1);
    end else if (p == MOD_W'(3)) begin
      g = '0;
    end else begin
      g = MOD_W'(3);
    end
    return g;
  endfunction

  // Set up the second exponentiation from the results of the first phase
  function automatic item_t enter_b(input item_t s);
    item_t t;
    t       = s;
    t.first = s.acc1;
    t.sq0   = s.acc0;
    t.acc0  = MOD_W'(1);
    t.e0    = (s.cmd == CMD_DECRYPT) ? (s.p - MOD_W'(2)) : s.e1;
    return t;
  endfunction

endpackage

// File: rtl/ebc_ifs.sv
// Valid/ready channel interfaces for requests, responses and register writes.
interface ebc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [ebc_pkg::BYTE_W-1:0]           plain_byte;
  logic [ebc_pkg::MOD_W-1:0]            ephemeral_exponent;
  logic [ebc_pkg::WORD_W-1:0]           cipher_first;
  logic [ebc_pkg::WORD_W-1:0]           cipher_second;
  modport source (output valid, command, plain_byte, ephemeral_exponent, cipher_first,
                  cipher_second, input ready);
  modport sink (input valid, command, plain_byte, ephemeral_exponent, cipher_first,
                cipher_second, output ready);
endinterface

interface ebc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ebc_pkg::MOD_W-1:0]  out_first;
  logic [ebc_pkg::MOD_W-1:0]  out_second;
  logic [ebc_pkg::BYTE_W-1:0] plain_out;
  logic                       status;
  modport source (output valid, out_first, out_second, plain_out, status, input ready);
  modport sink (input valid, out_first, out_second, plain_out, status, output ready);
endinterface

interface ebc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic                      index;
  logic [ebc_pkg::MOD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/elgamal_byte_cipher.sv
// Per-byte ElGamal encrypt/decrypt engine, fully pipelined over interleaved modular steps.
//
// Channels: req takes one command per transaction (encrypt a byte with exponent k, or
// decrypt a ciphertext pair); rsp returns exactly one result per request, in order.
// cfg writes the modulus (index 0) and the private key (index 1); it is always ready.
// Write cfg only while no request is in flight.
// Every modular multiply is one bit per stage: a round of square-and-multiply is 19
// stages. Phase one runs 3^x (or c1^x) beside 3^k for 19 rounds, phase two runs y^k
// (or s^(p-2)) for 19 rounds, phase three does the final multiply in 19 stages.
// The entry register is loaded at acceptance, and the item then passes through the
// 741-stage chain of bit-step units to the last stage register that drives rsp.valid.
// Throughput: one transaction per cycle while rsp is not stalled.
// Reset clears every stage valid bit and loads p = 257, x = 1.
// When rsp stalls with a result waiting, the whole pipeline holds and req.ready drops;
// nothing is lost or repeated.
module elgamal_byte_cipher (
  input  logic      clk,
  input  logic      rst,
  ebc_req_if.sink   req,
  ebc_rsp_if.source rsp,
  ebc_cfg_if.sink   cfg
);

  localparam int NS = ebc_pkg::NUM_STG;
  localparam int W  = ebc_pkg::MOD_W;

  logic [W-1:0]   prime;
  logic [W-1:0]   priv;
  ebc_pkg::item_t st [0:NS];
  ebc_pkg::item_t stg_next [0:NS-1];
  ebc_pkg::item_t in_item;
  logic [NS:0]    vld;
  logic           adv;

  // Register writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= ebc_pkg::PRIME_RESET;
      priv  <= ebc_pkg::PRIVATE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ebc_pkg::REG_PRIME:   prime <= cfg.data;
        ebc_pkg::REG_PRIVATE: priv  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Advance the whole chain unless a finished result is held
  assign adv       = !vld[NS] || rsp.ready;
  assign req.ready = adv;

  // Build the entering item
  always_comb begin
    logic [ebc_pkg::WORD_W-1:0] pw;
    logic [W-1:0]               g;
    pw = ebc_pkg::WORD_W'(prime);
    g  = ebc_pkg::gen_base(prime);
    in_item       = '0;
    in_item.cmd   = req.command;
    in_item.p     = prime;
    in_item.bad   = (req.command == ebc_pkg::CMD_DECRYPT) &&
                    ((prime <= W'(1)) || (req.cipher_first == '0) ||
                     (req.cipher_first >= pw) || (req.cipher_second >= pw));
    in_item.e0    = priv;
    in_item.e1    = req.ephemeral_exponent;
    in_item.acc0  = W'(1);
    in_item.acc1  = W'(1);
    in_item.sq0   = (req.command == ebc_pkg::CMD_DECRYPT) ? req.cipher_first[W-1:0] : g;
    in_item.sq1   = g;
    in_item.mult  = (req.command == ebc_pkg::CMD_DECRYPT) ? req.cipher_second[W-1:0]
                                                          : W'(req.plain_byte);
  end

  // One bit-step unit per stage
  for (genvar j = 0; j < NS; j++) begin : g_stg
    localparam int Ph  = (j < ebc_pkg::STEPS_A) ? 0 :
                         (j < ebc_pkg::STEPS_A + ebc_pkg::STEPS_B) ? 1 : 2;
    localparam int Off = (Ph == 0) ? j :
                         (Ph == 1) ? j - ebc_pkg::STEPS_A
                                   : j - ebc_pkg::STEPS_A - ebc_pkg::STEPS_B;
    localparam int Rd  = Off / ebc_pkg::MOD_W;
    localparam int Bt  = ebc_pkg::MOD_W - 1 - (Off % ebc_pkg::MOD_W);

    always_comb begin
      ebc_pkg::item_t cur;
      ebc_pkg::item_t nx;
      logic [W-1:0]   pa0_in;
      logic [W-1:0]   ps0_in;
      logic [W-1:0]   pa1_in;
      logic [W-1:0]   ps1_in;
      cur = st[j];
      if (Ph == 1 && Off == 0) begin
        cur = ebc_pkg::enter_b(st[j]);
      end
      nx     = cur;
      pa0_in = (Bt == W - 1) ? '0 : cur.pa0;
      ps0_in = (Bt == W - 1) ? '0 : cur.ps0;
      pa1_in = (Bt == W - 1) ? '0 : cur.pa1;
      ps1_in = (Bt == W - 1) ? '0 : cur.ps1;
      if (Ph == 2) begin
        nx.pa0 = ebc_pkg::mod_step(pa0_in, cur.acc0, cur.mult[Bt], cur.p);
      end else begin
        nx.pa0 = ebc_pkg::mod_step(pa0_in, cur.acc0, cur.sq0[Bt], cur.p);
        nx.ps0 = ebc_pkg::mod_step(ps0_in, cur.sq0, cur.sq0[Bt], cur.p);
        if (Ph == 0) begin
          nx.pa1 = ebc_pkg::mod_step(pa1_in, cur.acc1, cur.sq1[Bt], cur.p);
          nx.ps1 = ebc_pkg::mod_step(ps1_in, cur.sq1, cur.sq1[Bt], cur.p);
        end
        // Close the round: take the product on a set exponent bit, square always
        if (Bt == 0) begin
          if (cur.e0[Rd]) begin
            nx.acc0 = nx.pa0;
          end
          nx.sq0 = nx.ps0;
          if (Ph == 0) begin
            if (cur.e1[Rd]) begin
              nx.acc1 = nx.pa1;
            end
            nx.sq1 = nx.ps1;
          end
        end
      end
      stg_next[j] = nx;
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= in_item;
      for (int k = 0; k < NS; k++) begin
        st[k+1] <= stg_next[k];
      end
    end
  end

  // Valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:0], req.valid};
    end
  end

  // Form the result from the last stage
  always_comb begin
    logic enc;
    logic p_small;
    logic m_big;
    enc     = (st[NS].cmd == ebc_pkg::CMD_ENCRYPT);
    p_small = (st[NS].p <= W'(1));
    m_big   = (st[NS].pa0 > ebc_pkg::BYTE_MAX);
    rsp.valid      = vld[NS];
    rsp.out_first  = (enc && !p_small) ? st[NS].first : '0;
    rsp.out_second = (enc && !p_small) ? st[NS].pa0 : '0;
    rsp.status     = !enc && (st[NS].bad || m_big);
    rsp.plain_out  = (!enc && !st[NS].bad && !m_big) ? st[NS].pa0[ebc_pkg::BYTE_W-1:0] : '0;
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the per-byte ElGamal cipher engine.
`timescale 1ns / 1ps

module tb;

  localparam int DRAIN_CYCLES = 800;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int GAP_MAX      = 12;

  typedef struct {
    logic                       command;
    logic [ebc_pkg::BYTE_W-1:0] plain_byte;
    logic [ebc_pkg::MOD_W-1:0]  eph_exp;
    logic [ebc_pkg::WORD_W-1:0] c_first;
    logic [ebc_pkg::WORD_W-1:0] c_second;
    int                         gap;
    bit                         hold_drain;
  } cipher_req_t;

  typedef struct {
    logic [ebc_pkg::MOD_W-1:0]  out_first;
    logic [ebc_pkg::MOD_W-1:0]  out_second;
    logic [ebc_pkg::BYTE_W-1:0] plain_out;
    logic                       status;
  } cipher_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ebc_req_if req_ch();
  ebc_rsp_if rsp_ch();
  ebc_cfg_if cfg_ch();

  elgamal_byte_cipher i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  cipher_req_t pending_reqs[$];
  cipher_rsp_t expected_rsps[$];
  logic [ebc_pkg::MOD_W-1:0] mod_p   = ebc_pkg::PRIME_RESET;
  logic [ebc_pkg::MOD_W-1:0] priv_x  = ebc_pkg::PRIVATE_RESET;
  int  stall_max = GAP_MAX;
  int  errors    = 0;
  int  gap_cnt   = 0;
  int  stall_cnt = 0;
  int  stall_tgt = 0;
  longint cycles = 0;

  always #5 clk = ~clk;

  // Square-and-multiply with wide products
  function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e,
                                              longint unsigned p);
    longint unsigned acc;
    longint unsigned sq;
    if (p <= 1) return 0;
    acc = 1;
    sq  = base % p;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % p;
      sq = (sq * sq) % p;
      e  = e >> 1;
    end
    return acc;
  endfunction

  // Work out the result of one request under the current key
  function automatic cipher_rsp_t predict_cipher(cipher_req_t r);
    cipher_rsp_t     res;
    longint unsigned p;
    longint unsigned y;
    longint unsigned s;
    longint unsigned m;
    p   = mod_p;
    res = '{default: '0};
    if (r.command == ebc_pkg::CMD_ENCRYPT) begin
      if (p > 1) begin
        y = mod_pow(3, priv_x, p);
        res.out_first  = ebc_pkg::MOD_W'(mod_pow(3, r.eph_exp, p));
        res.out_second = ebc_pkg::MOD_W'((r.plain_byte * mod_pow(y, r.eph_exp, p)) % p);
      end
    end else if (p <= 1 || r.c_first == 0 || r.c_first >= p || r.c_second >= p) begin
      res.status = 1'b1;
    end else begin
      s = mod_pow(r.c_first, priv_x, p);
      m = (r.c_second * mod_pow(s, p - 2, p)) % p;
      if (m > 255) res.status = 1'b1;
      else res.plain_out = ebc_pkg::BYTE_W'(m);
    end
    return res;
  endfunction

  function automatic cipher_req_t mk_encrypt(logic [ebc_pkg::BYTE_W-1:0] m,
                                             logic [ebc_pkg::MOD_W-1:0] k, int gap);
    cipher_req_t r;
    r = '{command: ebc_pkg::CMD_ENCRYPT, plain_byte: m, eph_exp: k, c_first: $urandom(),
          c_second: $urandom(), gap: gap, hold_drain: 1'b0};
    return r;
  endfunction

  function automatic cipher_req_t mk_decrypt(logic [ebc_pkg::WORD_W-1:0] c1,
                                             logic [ebc_pkg::WORD_W-1:0] c2, int gap);
    cipher_req_t r;
    r = '{command: ebc_pkg::CMD_DECRYPT, plain_byte: ebc_pkg::BYTE_W'($urandom()),
          eph_exp: ebc_pkg::MOD_W'($urandom()), c_first: c1, c_second: c2, gap: gap,
          hold_drain: 1'b0};
    return r;
  endfunction

  // Wait for an empty engine, then let the pipeline run dry
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ebc_pkg::MOD_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == ebc_pkg::REG_PRIME) mod_p = value;
    else priv_x = value;
  endtask

  // Random traffic: mostly encrypt and round-trip decrypt, some junk ciphertexts
  task automatic queue_random(int count, bit calm);
    cipher_req_t     r;
    cipher_rsp_t     enc;
    longint unsigned p;
    int              gap;
    int              kind;
    for (int i = 0; i < count; i++) begin
      p    = mod_p;
      gap  = calm ? 0 : $urandom_range(0, GAP_MAX);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        r = mk_encrypt(ebc_pkg::BYTE_W'($urandom()),
                       ($urandom_range(0, 7) == 0) ? ebc_pkg::MOD_W'($urandom())
                       : ebc_pkg::MOD_W'($urandom_range(1, (p > 3) ? p - 2 : 1)), gap);
      end else if (kind < 8 && p > 3) begin
        r   = mk_encrypt(ebc_pkg::BYTE_W'($urandom()),
                         ebc_pkg::MOD_W'($urandom_range(1, p - 2)), gap);
        enc = predict_cipher(r);
        r   = mk_decrypt(ebc_pkg::WORD_W'(enc.out_first), ebc_pkg::WORD_W'(enc.out_second),
                         gap);
      end else if (kind == 8 && p > 1) begin
        r = mk_decrypt($urandom_range(0, p - 1), $urandom_range(0, p - 1), gap);
      end else begin
        r = mk_decrypt($urandom(), $urandom(), gap);
      end
      r.hold_drain = ($urandom_range(0, 199) == 0);
      pending_reqs.insert(pending_reqs.size(), r);
    end
  endtask

  task automatic run_phase(logic [ebc_pkg::MOD_W-1:0] p, logic [ebc_pkg::MOD_W-1:0] x,
                           int count, int stall);
    wait_idle();
    write_reg(ebc_pkg::REG_PRIME, p);
    write_reg(ebc_pkg::REG_PRIVATE, x);
    stall_max = stall;
    queue_random(count, stall == 0);
  endtask

  // Stimulus and end of run
  initial begin
    cipher_req_t r;
    cipher_rsp_t enc;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ebc_pkg::REG_PRIME;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed corners under the reset key
    pending_reqs.insert(pending_reqs.size(), mk_encrypt(8'd0, 19'd0, 0));
    pending_reqs.insert(pending_reqs.size(), mk_encrypt(8'd255, 19'd1, 0));
    pending_reqs.insert(pending_reqs.size(), mk_encrypt(8'd255, 19'd255, 3));
    pending_reqs.insert(pending_reqs.size(), mk_encrypt(8'd1, 19'h7FFFF, 0));
    pending_reqs.insert(pending_reqs.size(), mk_encrypt(8'h5A, 19'h2AAAA, 0));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'd0, 32'd5, 0));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'd257, 32'd5, 0));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'd5, 32'd257, 1));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'hFFFFFFFF, 32'd1, 0));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'd1, 32'hFFFFFFFF, 0));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'd1, 32'd255, 0));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'd1, 32'd256, 0));
    pending_reqs.insert(pending_reqs.size(), mk_decrypt(32'd256, 32'd0, 2));
    r   = mk_encrypt(8'd200, 19'd77, 0);
    enc = predict_cipher(r);
    pending_reqs.insert(pending_reqs.size(), r);
    pending_reqs.insert(pending_reqs.size(),
                        mk_decrypt(ebc_pkg::WORD_W'(enc.out_first),
                                   ebc_pkg::WORD_W'(enc.out_second), 0));
    r = mk_encrypt(8'd17, 19'd9, 0);
    r.hold_drain = 1'b1;
    pending_reqs.insert(pending_reqs.size(), r);
    queue_random(300, 1'b0);

    run_phase(19'd499979, 19'd499977, 350, GAP_MAX);
    run_phase(19'd65537, ebc_pkg::MOD_W'($urandom_range(1, 65535)), 350, 0);
    run_phase(19'd7919, ebc_pkg::MOD_W'($urandom_range(1, 7917)), 350, GAP_MAX);
    run_phase(19'd104729, ebc_pkg::MOD_W'($urandom_range(1, 104727)), 350, GAP_MAX);
    run_phase(19'd257, 19'd255, 150, GAP_MAX);
    // Degenerate and unusual moduli
    run_phase(19'd0, 19'd1, 20, GAP_MAX);
    run_phase(19'd1, 19'd0, 20, GAP_MAX);
    run_phase(19'd2, 19'd1, 20, GAP_MAX);
    run_phase(19'd3, 19'd1, 20, GAP_MAX);
    run_phase(19'h7FFFF, 19'h7FFFF, 40, GAP_MAX);
    run_phase(19'd257, 19'd0, 30, GAP_MAX);

    wait_idle();
    if (errors == 0 && expected_rsps.size() == 0 && pending_reqs.size() == 0) begin
      $display("PASS elgamal_byte_cipher");
    end else begin
      $display("FAIL elgamal_byte_cipher");
    end
    $finish;
  end

  // Request driver: hold on stall, record each transaction, then present the next item
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid              <= 1'b0;
      req_ch.command            <= ebc_pkg::CMD_ENCRYPT;
      req_ch.plain_byte         <= '0;
      req_ch.ephemeral_exponent <= '0;
      req_ch.cipher_first       <= '0;
      req_ch.cipher_second      <= '0;
    end else if (!(req_ch.valid && !req_ch.ready)) begin
      if (req_ch.valid) begin
        expected_rsps.insert(expected_rsps.size(), predict_cipher('{command: req_ch.command,
          plain_byte: req_ch.plain_byte, eph_exp: req_ch.ephemeral_exponent,
          c_first: req_ch.cipher_first, c_second: req_ch.cipher_second, gap: 0,
          hold_drain: 1'b0}));
      end
      if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (gap_cnt < pending_reqs[0].gap) begin
        gap_cnt++;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs[0].hold_drain && expected_rsps.size() != 0) begin
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid              <= 1'b1;
        req_ch.command            <= pending_reqs[0].command;
        req_ch.plain_byte         <= pending_reqs[0].plain_byte;
        req_ch.ephemeral_exponent <= pending_reqs[0].eph_exp;
        req_ch.cipher_first       <= pending_reqs[0].c_first;
        req_ch.cipher_second      <= pending_reqs[0].c_second;
        void'(pending_reqs.pop_front());
        gap_cnt = 0;
      end
    end
  end

  // Response monitor: compare each transaction, then draw the next stall
  always @(posedge clk) begin
    cipher_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result first=%0d second=%0d plain=%0d status=%0d", $time,
                   rsp_ch.out_first, rsp_ch.out_second, rsp_ch.plain_out, rsp_ch.status);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.out_first !== want.out_first || rsp_ch.out_second !== want.out_second ||
              rsp_ch.plain_out !== want.plain_out || rsp_ch.status !== want.status) begin
            errors++;
            $display("%0t: mismatch expected first=%0d second=%0d plain=%0d status=%0d",
                     $time, want.out_first, want.out_second, want.plain_out, want.status);
            $display("%0t:          actual   first=%0d second=%0d plain=%0d status=%0d",
                     $time, rsp_ch.out_first, rsp_ch.out_second, rsp_ch.plain_out,
                     rsp_ch.status);
          end
        end
        stall_tgt = $urandom_range(0, stall_max);
        stall_cnt = 0;
      end
      if (stall_cnt >= stall_tgt) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall_cnt++;
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rsps.size());
      $display("FAIL elgamal_byte_cipher");
      $finish;
    end
  end

endmodule
